### hw/rtl/mbpc_pkg.sv
// mbpc_pkg: shared widths, reset values and register index codes for the
// multi-button press classifier
// no dependencies
package mbpc_pkg;

   // payload widths
   localparam int TIME_W     = 32;
   localparam int PIN_W      = 4;
   localparam int EVENT_W    = 4;
   localparam int THR_W      = 16;
   localparam int MASK_W     = 4;

   // configuration port widths
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // default button count
   localparam int NUM_BUTTONS_DEF = 4;

   // register reset values
   localparam logic [THR_W-1:0]  LONG_PRESS_RST      = 16'd500;
   localparam logic [THR_W-1:0]  LAST_LONG_PRESS_RST = 16'd800;
   localparam logic [THR_W-1:0]  LOCKOUT_RST         = 16'd20;
   localparam logic [MASK_W-1:0] ACTIVE_HIGH_RST     = 4'd8;

   // register index codes
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_LONG_PRESS = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT         = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_HIGH     = 8'd3;

endpackage

### hw/rtl/multi_button_press_classifier.sv
// multi_button_press_classifier: polls button levels and reports short and
// long presses with a global lockout after transitions
// depends on mbpc_pkg
//
// Usage
//  req channel: one beat per poll, carrying a millisecond timestamp and the
//  raw levels of the buttons. rsp channel: exactly one beat per poll, the
//  event code (0 none, 2*i+1 short press of button i, 2*i+2 long press).
//  csr channel: register writes by index, always ready; write only while
//  no poll is in flight.
//  Timing: a poll accepted into the input register is classified from it
//  and its event is loaded into the result register, which drives rsp.
//  Throughput: one poll per cycle while rsp is not stalled; the per-button
//  compare and priority scan all sit between the input register and the
//  result register, and the button state (unless locked out) updates in
//  the same cycle as the result register, so the next poll sees it at once.
//  Reset: thresholds return to 500, 800 and 20 ms, only the last button is
//  active-high, no button is held and the last transition time is zero.
//  Stall: while rsp_ready is low the result holds, one more poll may wait
//  in the input register, and req_ready drops after that.
module multi_button_press_classifier #(
   parameter int NUM_BUTTONS = mbpc_pkg::NUM_BUTTONS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // poll channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mbpc_pkg::TIME_W-1:0]      req_now_ms,
   input  logic [mbpc_pkg::PIN_W-1:0]       req_pin_levels,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mbpc_pkg::EVENT_W-1:0]     rsp_event_res,
   // register write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mbpc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbpc_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int TIME_W  = mbpc_pkg::TIME_W;
   localparam int THR_W   = mbpc_pkg::THR_W;
   localparam int EVENT_W = mbpc_pkg::EVENT_W;
   localparam int EXT_W   = (NUM_BUTTONS > mbpc_pkg::PIN_W) ? NUM_BUTTONS
                                                            : mbpc_pkg::PIN_W;

   typedef logic [TIME_W-1:0] time_type;

   // configuration registers
   logic [THR_W-1:0]            long_thr_ff;
   logic [THR_W-1:0]            last_thr_ff;
   logic [THR_W-1:0]            lockout_ff;
   logic [mbpc_pkg::MASK_W-1:0] act_high_ff;

   // input and result stages
   logic                        in_vld_ff;
   time_type                    in_now_ff;
   logic [mbpc_pkg::PIN_W-1:0]  in_pins_ff;
   logic                        out_vld_ff;
   logic [EVENT_W-1:0]          event_ff;
   logic [EVENT_W-1:0]          event_in;

   // button state
   time_type                    last_trans_ff;
   time_type                    last_trans_in;
   logic [NUM_BUTTONS-1:0]      held_ff;
   logic [NUM_BUTTONS-1:0]      held_in;
   logic [NUM_BUTTONS-1:0]      lrep_ff;
   logic [NUM_BUTTONS-1:0]      lrep_in;
   time_type                    start_ff [NUM_BUTTONS];
   time_type                    start_in [NUM_BUTTONS];

   logic                        move;
   logic                        locked;
   logic                        commit;
   logic [EXT_W-1:0]            lvl_ext;
   logic [EXT_W-1:0]            mask_ext;
   logic [NUM_BUTTONS-1:0]      pressed;
   logic [EVENT_W-1:0]          scan_event;
   logic                        scan_trans;

   // handshakes
   assign move      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || move;
   assign rsp_valid = out_vld_ff;
   assign rsp_event_res = event_ff;
   assign csr_ready = 1'b1;

   // register writes, unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         long_thr_ff <= mbpc_pkg::LONG_PRESS_RST;
         last_thr_ff <= mbpc_pkg::LAST_LONG_PRESS_RST;
         lockout_ff  <= mbpc_pkg::LOCKOUT_RST;
         act_high_ff <= mbpc_pkg::ACTIVE_HIGH_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            mbpc_pkg::CSR_LONG_PRESS:      long_thr_ff <= csr_data;
            mbpc_pkg::CSR_LAST_LONG_PRESS: last_thr_ff <= csr_data;
            mbpc_pkg::CSR_LOCKOUT:         lockout_ff  <= csr_data;
            mbpc_pkg::CSR_ACTIVE_HIGH:     act_high_ff <= csr_data[mbpc_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_now_ff  <= req_now_ms;
         in_pins_ff <= req_pin_levels;
      end
   end

   // pressed decode; buttons without a pin read low and active-low
   assign lvl_ext  = EXT_W'(in_pins_ff);
   assign mask_ext = EXT_W'(act_high_ff);
   assign pressed  = ~(lvl_ext[NUM_BUTTONS-1:0] ^ mask_ext[NUM_BUTTONS-1:0]);

   // global lockout since the last transition
   assign locked = (in_now_ff - last_trans_ff) < time_type'(lockout_ff);
   assign commit = move && !locked;

   // priority scan, first event ends it
   always_comb begin
      logic              found;
      logic              hit;
      logic [THR_W-1:0]  thr;
      time_type          elapsed;
      found      = 1'b0;
      hit        = 1'b0;
      thr        = long_thr_ff;
      elapsed    = '0;
      scan_event = '0;
      scan_trans = 1'b0;
      held_in    = held_ff;
      lrep_in    = lrep_ff;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         start_in[b] = start_ff[b];
      end
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         thr     = (b == NUM_BUTTONS - 1) ? last_thr_ff : long_thr_ff;
         elapsed = in_now_ff - start_ff[b];
         hit     = 1'b0;
         if (!found) begin
            if (pressed[b]) begin
               if (!held_ff[b]) begin
                  // new press: elapsed is zero, long only at zero threshold
                  held_in[b]  = 1'b1;
                  start_in[b] = in_now_ff;
                  lrep_in[b]  = 1'b0;
                  scan_trans  = 1'b1;
                  hit         = (thr == '0);
               end else begin
                  hit = !lrep_ff[b] && (elapsed >= time_type'(thr));
               end
               if (hit) begin
                  lrep_in[b] = 1'b1;
                  scan_trans = 1'b1;
                  scan_event = EVENT_W'(2 * b + 2);
                  found      = 1'b1;
               end
            end else if (held_ff[b]) begin
               held_in[b] = 1'b0;
               scan_trans = 1'b1;
               if (!lrep_ff[b] && (elapsed < time_type'(thr))) begin
                  scan_event = EVENT_W'(2 * b + 1);
                  found      = 1'b1;
               end
            end
         end
      end
   end

   assign event_in      = locked ? '0 : scan_event;
   assign last_trans_in = scan_trans ? in_now_ff : last_trans_ff;

   // button state update
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff       <= '0;
         lrep_ff       <= '0;
         last_trans_ff <= '0;
      end else if (commit) begin
         held_ff       <= held_in;
         lrep_ff       <= lrep_in;
         last_trans_ff <= last_trans_in;
      end
   end

   // press start times, read only while held
   always_ff @(posedge clock) begin
      if (commit) begin
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            start_ff[b] <= start_in[b];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_ready) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         event_ff <= event_in;
      end
   end

`ifndef SYNTHESIS
   // a locked poll yields no event
   assert property (@(posedge clock) disable iff (reset)
      move && locked |=> event_ff == '0)
      else $error("event reported during lockout");

   // an event moves the last transition time to its poll
   assert property (@(posedge clock) disable iff (reset)
      commit && scan_event != '0 |=> last_trans_ff == $past(in_now_ff))
      else $error("event without transition time update");

   // a new hold of button 0 records the poll time
   assert property (@(posedge clock) disable iff (reset)
      $rose(held_ff[0]) |-> start_ff[0] == $past(in_now_ff))
      else $error("press start time not recorded");

   // an empty result stage never blocks polls
   assert property (@(posedge clock) disable iff (reset)
      !out_vld_ff |-> req_ready)
      else $error("poll blocked with empty result stage");

   // event codes stay within the button count
   assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> int'(event_ff) <= 2 * NUM_BUTTONS)
      else $error("event code out of range");
`endif

endmodule

### tb/testbench.sv
// testbench: directed and random regression for multi_button_press_classifier
// every result beat is scored against an in-bench classifier fed the same polls
// depends on mbpc_pkg and the multi_button_press_classifier rtl
module testbench;

   localparam int NB          = mbpc_pkg::NUM_BUTTONS_DEF;
   localparam int SETTLE_CYC  = 6;
   localparam int CYCLE_LIMIT = 400000;

   localparam int TIME_W      = mbpc_pkg::TIME_W;
   localparam int PIN_W       = mbpc_pkg::PIN_W;
   localparam int EVENT_W     = mbpc_pkg::EVENT_W;
   localparam int THR_W       = mbpc_pkg::THR_W;
   localparam int MASK_W      = mbpc_pkg::MASK_W;
   localparam int CSR_IDX_W   = mbpc_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = mbpc_pkg::CSR_DATA_W;

   // register indexes the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 8'hFF;

   typedef enum logic [1:0] {CMD_POLL, CMD_REG, CMD_DRAIN, CMD_PHASE} cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [TIME_W-1:0]      now_ms;
      logic [PIN_W-1:0]       pins;
      logic [CSR_IDX_W-1:0]   reg_idx;
      logic [CSR_DATA_W-1:0]  reg_data;
      logic [6:0]             send_pct;
      logic [6:0]             recv_pct;
   } script_cmd_type;

   // block ports
   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   req_valid      = 1'b0;
   logic                   req_ready;
   logic [TIME_W-1:0]      req_now_ms     = '0;
   logic [PIN_W-1:0]       req_pin_levels = '0;
   logic                   rsp_valid;
   logic                   rsp_ready      = 1'b0;
   logic [EVENT_W-1:0]     rsp_event_res;
   logic                   csr_valid      = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index      = '0;
   logic [CSR_DATA_W-1:0]  csr_data       = '0;

   // classifier mirror: registers and button state
   logic [THR_W-1:0]   thr_long     = mbpc_pkg::LONG_PRESS_RST;
   logic [THR_W-1:0]   thr_last     = mbpc_pkg::LAST_LONG_PRESS_RST;
   logic [THR_W-1:0]   lockout_len  = mbpc_pkg::LOCKOUT_RST;
   logic [MASK_W-1:0]  polarity     = mbpc_pkg::ACTIVE_HIGH_RST;
   logic [TIME_W-1:0]  last_edge_ms = '0;
   logic [NB-1:0]      held         = '0;
   logic [NB-1:0]      long_sent    = '0;
   logic [TIME_W-1:0]  press_ms [NB];

   // poll script, expected events and bookkeeping
   script_cmd_type      poll_script [$];
   logic [EVENT_W-1:0]  expected_events [$];
   script_cmd_type      next_cmd;
   logic                next_req_valid;
   logic                next_csr_valid;
   logic [EVENT_W-1:0]  want_event;
   int unsigned         settle_left    = 0;
   int unsigned         send_idle_pct  = 0;
   int unsigned         recv_stall_pct = 0;
   int unsigned         polls_taken    = 0;
   int unsigned         events_seen    = 0;
   int unsigned         mismatches     = 0;
   int unsigned         cycles         = 0;
   logic                script_done    = 1'b0;
   int unsigned         send_mix [4]   = '{0, 87, 0, 26};
   int unsigned         recv_mix [4]   = '{0, 0, 87, 26};

   multi_button_press_classifier #(.NUM_BUTTONS(NB)) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_now_ms     (req_now_ms),
      .req_pin_levels (req_pin_levels),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_res  (rsp_event_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      for (int b = 0; b < NB; b++) press_ms[b] = '0;
   end

   initial forever #2 clock = ~clock;

   // one line per mismatch, and a count
   task automatic flag_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   // register write as the block decodes it
   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      case (idx)
         mbpc_pkg::CSR_LONG_PRESS:      thr_long    = data[THR_W-1:0];
         mbpc_pkg::CSR_LAST_LONG_PRESS: thr_last    = data[THR_W-1:0];
         mbpc_pkg::CSR_LOCKOUT:         lockout_len = data[THR_W-1:0];
         mbpc_pkg::CSR_ACTIVE_HIGH:     polarity    = data[MASK_W-1:0];
         default: ;
      endcase
   endfunction

   // event for one poll, updating the mirrored button state
   function automatic logic [EVENT_W-1:0] classify_poll(input logic [TIME_W-1:0] now,
                                                        input logic [PIN_W-1:0] pins);
      logic [EVENT_W-1:0] code;
      logic [TIME_W-1:0]  thr;
      logic [TIME_W-1:0]  gap;
      logic               pressed;
      logic               found;
      code  = '0;
      found = 1'b0;
      gap   = now - last_edge_ms;
      thr   = TIME_W'(lockout_len);
      if (gap < thr) return code;
      // priority scan, first event wins
      for (int b = 0; b < NB; b++) begin
         if (!found) begin
            // buttons past the pin field read low with active-low polarity
            if (b < PIN_W) pressed = polarity[b] ? pins[b] : !pins[b];
            else pressed = 1'b1;
            thr = (b == NB - 1) ? TIME_W'(thr_last) : TIME_W'(thr_long);
            if (pressed) begin
               if (!held[b]) begin
                  held[b]      = 1'b1;
                  press_ms[b]  = now;
                  long_sent[b] = 1'b0;
                  last_edge_ms = now;
               end
               if (!long_sent[b] && (now - press_ms[b]) >= thr) begin
                  long_sent[b] = 1'b1;
                  last_edge_ms = now;
                  code         = EVENT_W'(2 * b + 2);
                  found        = 1'b1;
               end
            end else if (held[b]) begin
               held[b]      = 1'b0;
               last_edge_ms = now;
               if (!long_sent[b] && (now - press_ms[b]) < thr) begin
                  code  = EVENT_W'(2 * b + 1);
                  found = 1'b1;
               end
            end
         end
      end
      return code;
   endfunction

   // script building
   task automatic add_poll(input logic [TIME_W-1:0] now, input logic [PIN_W-1:0] pins);
      poll_script.push_back('{CMD_POLL, now, pins, '0, '0, '0, '0});
   endtask

   task automatic add_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      poll_script.push_back('{CMD_REG, '0, '0, idx, data, '0, '0});
   endtask

   task automatic add_drain();
      poll_script.push_back('{CMD_DRAIN, '0, '0, '0, '0, '0, '0});
   endtask

   task automatic add_phase(input int unsigned send_pct, input int unsigned recv_pct);
      poll_script.push_back('{CMD_PHASE, '0, '0, '0, '0, 7'(send_pct), 7'(recv_pct)});
   endtask

   function automatic logic [THR_W-1:0] pick_threshold();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return THR_W'($urandom_range(1, 150));
      endcase
   endfunction

   // driver: presents script entries, feeds the mirror on accepted beats
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         next_req_valid = req_valid && !req_ready;
         next_csr_valid = csr_valid && !csr_ready;
         if (req_valid && req_ready) begin
            expected_events.push_back(classify_poll(req_now_ms, req_pin_levels));
            polls_taken++;
         end
         if (csr_valid && csr_ready) apply_reg(csr_index, csr_data);
         if (!next_req_valid && !next_csr_valid) begin
            if (settle_left > 0) begin
               settle_left--;
            end else if (poll_script.size() == 0) begin
               if (polls_taken == events_seen) script_done <= 1'b1;
            end else begin
               next_cmd = poll_script[0];
               case (next_cmd.kind)
                  CMD_POLL: begin
                     if ($urandom_range(0, 99) >= send_idle_pct) begin
                        poll_script.delete(0);
                        next_req_valid  = 1'b1;
                        req_now_ms     <= next_cmd.now_ms;
                        req_pin_levels <= next_cmd.pins;
                     end
                  end
                  CMD_REG: begin
                     poll_script.delete(0);
                     next_csr_valid  = 1'b1;
                     csr_index      <= next_cmd.reg_idx;
                     csr_data       <= next_cmd.reg_data;
                  end
                  CMD_DRAIN: begin
                     // hold off until every poll has its event back
                     if (polls_taken == events_seen) begin
                        poll_script.delete(0);
                        settle_left = SETTLE_CYC;
                     end
                  end
                  CMD_PHASE: begin
                     poll_script.delete(0);
                     send_idle_pct   = 32'(next_cmd.send_pct);
                     recv_stall_pct <= 32'(next_cmd.recv_pct);
                  end
                  default: poll_script.delete(0);
               endcase
            end
         end
         req_valid <= next_req_valid;
         csr_valid <= next_csr_valid;
      end
   end

   // monitor: scores each result beat against the oldest expected event
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               flag_mismatch($sformatf("event_res %0d with no poll outstanding",
                                       rsp_event_res));
            end else begin
               want_event = expected_events.pop_front();
               if (rsp_event_res !== want_event)
                  flag_mismatch($sformatf("event_res got %0d want %0d on result %0d",
                                          rsp_event_res, want_event, events_seen));
            end
            events_seen <= events_seen + 1;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      logic [TIME_W-1:0] t;
      logic [PIN_W-1:0]  pins;
      int                sel;

      // directed polls, reset settings, no idling
      add_phase(0, 0);
      // lockout right after reset, then a short press of button 0
      add_poll(32'd5, 4'h7);
      add_poll(32'd20, 4'h7);
      add_poll(32'd30, 4'h6);
      add_poll(32'd45, 4'h7);
      add_poll(32'd60, 4'h7);
      // long press of the last button, its release stays quiet
      add_poll(32'd100, 4'hF);
      add_poll(32'd910, 4'hF);
      add_poll(32'd1000, 4'h7);
      // long press of button 1, then several buttons at once
      add_poll(32'd1100, 4'h5);
      add_poll(32'd1600, 4'h5);
      add_poll(32'd1700, 4'h0);
      add_poll(32'd1750, 4'hF);
      add_poll(32'd1800, 4'hF);
      // press and release across the timestamp wrap
      add_poll(32'hFFFF_FFF0, 4'h3);
      add_poll(32'h0000_0020, 4'h7);
      add_poll(32'hFFFF_FFFF, 4'h8);
      // zero threshold reports long on the first poll that sees the hold
      add_drain();
      add_reg(mbpc_pkg::CSR_LONG_PRESS, 16'd0);
      add_poll(32'h0000_0100, 4'h8);
      add_poll(32'h0000_0200, 4'h8);
      // no lockout, all active-high, widest last threshold, undecoded indexes
      add_drain();
      add_reg(mbpc_pkg::CSR_LOCKOUT, 16'd0);
      add_reg(mbpc_pkg::CSR_LAST_LONG_PRESS, 16'hFFFF);
      add_reg(mbpc_pkg::CSR_ACTIVE_HIGH, 16'hFFFF);
      add_reg(CSR_SPARE_LO, 16'h5A5A);
      add_reg(CSR_SPARE_HI, 16'hA5A5);
      add_poll(32'h0000_0300, 4'h0);
      add_poll(32'h0000_0300, 4'hF);
      add_poll(32'h0000_0300, 4'hF);
      add_poll(32'h0000_0300, 4'hF);
      add_poll(32'h0000_0300, 4'hF);
      // widest lockout, all active-low
      add_drain();
      add_reg(mbpc_pkg::CSR_LOCKOUT, 16'hFFFF);
      add_reg(mbpc_pkg::CSR_ACTIVE_HIGH, 16'h0000);
      add_poll(32'h0000_0400, 4'hF);
      add_poll(32'h0001_0400, 4'hF);

      // random press sequences under changing settings and idling
      for (int p = 0; p < 4; p++) begin
         add_phase(send_mix[p], recv_mix[p]);
         t    = $urandom();
         pins = PIN_W'($urandom_range(0, 15));
         for (int blk = 0; blk < 5; blk++) begin
            add_drain();
            add_reg(mbpc_pkg::CSR_LONG_PRESS, pick_threshold());
            add_reg(mbpc_pkg::CSR_LAST_LONG_PRESS, pick_threshold());
            add_reg(mbpc_pkg::CSR_LOCKOUT,
                    ($urandom_range(0, 29) == 0) ? 16'hFFFF : 16'($urandom_range(0, 30)));
            add_reg(mbpc_pkg::CSR_ACTIVE_HIGH, 16'($urandom_range(0, 15)));
            if ($urandom_range(0, 3) == 0) add_reg(CSR_SPARE_LO, 16'($urandom()));
            for (int k = 0; k < 50; k++) begin
               // mostly small forward steps, now and then a jump anywhere
               case ($urandom_range(0, 19))
                  0:       t = $urandom();
                  1:       ;
                  default: t = t + $urandom_range(1, 40);
               endcase
               // mostly hold, sometimes flip one button, rarely scramble all
               case ($urandom_range(0, 9))
                  0: pins = PIN_W'($urandom_range(0, 15));
                  1, 2, 3: begin
                     sel       = $urandom_range(0, PIN_W - 1);
                     pins[sel] = ~pins[sel];
                  end
                  default: ;
               endcase
               add_poll(t, pins);
               if ($urandom_range(0, 99) == 0) add_drain();
            end
         end
      end
      add_drain();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (script_done);
      if (expected_events.size() != 0)
         flag_mismatch($sformatf("%0d expected events never came back",
                                 expected_events.size()));
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
